// File: src/shft_pkg.sv
// ----------------------------------------------------------------------------
// shft_pkg: shared types and constants of the super-spreader flow table
// Slot layout, HyperLogLog geometry, hash constants, transaction payloads and
// the controller state encoding.
// ----------------------------------------------------------------------------
package shft_pkg;

  // table geometry (NUM_REGS and NSLOTS must be powers of two)
  localparam int TOP_SLOTS   = 512;
  localparam int PROMO_SLOTS = 512;
  localparam int NUM_REGS    = 256;
  localparam int NSLOTS      = TOP_SLOTS + PROMO_SLOTS;
  localparam int SLOT_W      = $clog2(NSLOTS);
  localparam int REG_W       = $clog2(NUM_REGS);
  localparam int HLL_DEPTH   = NSLOTS * NUM_REGS;
  localparam int HLL_AW      = $clog2(HLL_DEPTH);
  localparam int ROUGH_W     = 40;
  localparam int STEP_LAST   = 8;

  // hash constants
  localparam logic [31:0] SEED_IDX = 32'd51318471;
  localparam logic [31:0] SEED_RHO = 32'd51318471 + 32'd15417891;
  localparam logic [31:0] MM_C1    = 32'hcc9e2d51;
  localparam logic [31:0] MM_C2    = 32'h1b873593;
  localparam logic [31:0] MM_C3    = 32'h85ebca6b;
  localparam logic [31:0] MM_C4    = 32'hc2b2ae35;
  localparam logic [31:0] MM_ADD   = 32'he6546b64;
  localparam logic [4:0]  RHO_MAX  = 5'd31;
  localparam logic [ROUGH_W-1:0] ROUGH_MAX = '1;

  typedef enum logic [0:0] {
    CFG_WEIGHT_THR = 1'b0,
    CFG_PKT_MARGIN = 1'b1
  } cfg_idx_e;

  typedef enum logic [0:0] {
    OP_INSERT = 1'b0,
    OP_LOOKUP = 1'b1
  } op_e;

  typedef struct packed {
    logic        op;
    logic [31:0] flow_key;
    logic [31:0] element;
    logic [7:0]  reg_select;
  } req_t;

  typedef struct packed {
    logic               tracked;
    logic [9:0]         slot;
    logic               evicted;
    logic [31:0]        evicted_key;
    logic [ROUGH_W-1:0] rough_sum;
    logic [8:0]         nonzero_regs;
    logic [4:0]         reg_value;
  } res_t;

  typedef struct packed {
    logic [31:0]        key;
    logic [SLOT_W-1:0]  sketch;
    logic [ROUGH_W-1:0] rough;
    logic [7:0]         nzm1;
  } slot_t;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_HASH, S_SRCH_RD, S_SRCH_CMP, S_DISPATCH,
    S_UPD_RD, S_UPD_CHK, S_BUB_RD, S_BUB_CMP, S_BUB_WR, S_NEW_WR,
    S_WEAK_RD, S_WEAK_CHK, S_EV_CLR, S_EV_PRD, S_EV_PWR, S_EV_NWR,
    S_SEL_RD, S_EMIT
  } state_e;

  function automatic logic [31:0] rotl(input logic [31:0] x, input int r);
    return (x << r) | (x >> (32 - r));
  endfunction

  // leading zero count, 32 for a zero word
  function automatic logic [5:0] lzc32(input logic [31:0] x);
    logic [5:0] n;
    n = 6'd32;
    for (int i = 0; i < 32; i++) begin
      if (x[i]) n = 6'(31 - i);
    end
    return n;
  endfunction

  function automatic logic [HLL_AW-1:0] hll_addr(input logic [SLOT_W-1:0] sk,
                                                 input logic [REG_W-1:0] rg);
    return HLL_AW'(HLL_AW'(sk) * HLL_AW'(NUM_REGS)) + HLL_AW'(rg);
  endfunction

endpackage

// File: src/shft_ram.sv
// ----------------------------------------------------------------------------
// shft_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module shft_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/top_spreader_hll_flow_table.sv
// ----------------------------------------------------------------------------
// top_spreader_hll_flow_table: super-spreader flow table with HyperLogLog
// Flow slots in one RAM, sketch registers in a second RAM; a sequencer
// hashes, searches, updates and swaps entries through those two ports.
// ----------------------------------------------------------------------------
// Sequence: a two-pass hash, a compare per slot searched (one more search
//   read on a miss), then update and readback; an eviction adds a clear of
//   the victim's 256 sketch registers. One result strobe, registered from emit.
// Throughput: one transaction at a time; busy stays high until its result.
// The slot search runs through the single slot RAM read port, slot by slot.
// Reset: a clearing pass writes all 262144 sketch registers to zero, one per
//   cycle, with busy high; config writes are taken throughout.
module top_spreader_hll_flow_table (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  shft_pkg::req_t req_i,
  output logic           res_valid_o,
  output shft_pkg::res_t res_o,
  input  logic           cfg_valid_i,
  output logic           cfg_ready_o,
  input  logic           cfg_index_i,
  input  logic [31:0]    cfg_data_i
);
  import shft_pkg::*;

  state_e            state_q, state_d;
  req_t              req_q, req_d;
  logic [31:0]       h_q, h_d, k_q, k_d;
  logic [3:0]        step_q, step_d;
  logic              phase_q, phase_d;
  logic [REG_W-1:0]  ridx_q, ridx_d;
  logic [4:0]        rho_q, rho_d;
  logic [SLOT_W:0]   idx_q, idx_d;
  logic              found_q, found_d;
  logic [SLOT_W:0]   occ_q, occ_d;
  logic [SLOT_W-1:0] ptr_q, ptr_d;
  logic [31:0]       psk_q, psk_d;
  logic [7:0]        thr_q, thr_d;
  logic [31:0]       margin_q, margin_d;
  slot_t             cur_q, cur_d, nbr_q, nbr_d;
  logic [SLOT_W-1:0] pos_q, pos_d, ks_q, ks_d;
  logic [31:0]       ekey_q, ekey_d;
  logic              evicted_q, evicted_d, hit_q, hit_d;
  logic [HLL_AW-1:0] cnt_q, cnt_d;
  res_t              res_q, res_d;
  logic              res_valid_q, res_valid_d;

  // memory ports
  logic              slot_we;
  logic [SLOT_W-1:0] slot_waddr, slot_raddr;
  slot_t             slot_wdata, slot_rdata;
  logic              hll_we;
  logic [HLL_AW-1:0] hll_waddr, hll_raddr;
  logic [4:0]        hll_wdata, hll_rdata;

  shft_ram #(.WIDTH($bits(slot_t)), .DEPTH(NSLOTS)) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (slot_we),
    .waddr_i (slot_waddr),
    .wdata_i (slot_wdata),
    .raddr_i (slot_raddr),
    .rdata_o (slot_rdata)
  );

  shft_ram #(.WIDTH(5), .DEPTH(HLL_DEPTH)) u_hll_ram (
    .clk_i   (clk_i),
    .we_i    (hll_we),
    .waddr_i (hll_waddr),
    .wdata_i (hll_wdata),
    .raddr_i (hll_raddr),
    .rdata_o (hll_rdata)
  );

  // shared decisions
  logic              accept, srch_end, key_match, grow, bub_ok, bub_swap, kick;
  logic              clr_last, ev_last;
  logic [31:0]       fin;
  logic [5:0]        lz_p1;
  logic [8:0]        w_n;
  logic [3:0]        w_scale;
  logic [35:0]       w_prod;
  logic [ROUGH_W-1:0] w_fair;
  logic [SLOT_W-1:0] prom;
  logic [ROUGH_W:0]  upd_sum;
  logic [ROUGH_W-1:0] ev_rough;

  assign accept    = start && (state_q == S_IDLE);
  assign srch_end  = (idx_q >= occ_q);
  assign key_match = (slot_rdata.key == req_q.flow_key);
  assign grow      = (rho_q > hll_rdata);
  assign bub_ok    = (pos_q != '0) && (32'(pos_q) < TOP_SLOTS);
  assign bub_swap  = (cur_q.rough > slot_rdata.rough);
  assign clr_last  = (32'(cnt_q) == HLL_DEPTH - 1);
  assign ev_last   = (32'(cnt_q[REG_W-1:0]) == NUM_REGS - 1);
  assign fin       = h_q ^ (h_q >> 16);
  assign lz_p1     = lzc32(fin) + 6'd1;

  // weak top flow test
  assign w_n     = {1'b0, slot_rdata.nzm1} + 9'd1;
  assign w_scale = (w_n > {1'b0, thr_q}) ? 4'(4'd1 + 4'(w_n >> 5)) : 4'd1;
  assign w_prod  = 36'((36'(1) << rho_q) - 36'(1)) * 36'(w_scale);
  assign w_fair  = ROUGH_W'(NUM_REGS) + ROUGH_W'(w_prod);
  assign kick    = (w_fair > slot_rdata.rough) ||
                   ((w_n < {1'b0, thr_q}) && (psk_q > margin_q));

  // promotion slot, kept inside the promotion zone
  assign prom = ((32'(ptr_q) < TOP_SLOTS) || (32'(ptr_q) >= NSLOTS)) ?
                SLOT_W'(TOP_SLOTS) : ptr_q;

  assign upd_sum  = {1'b0, cur_q.rough} + ((ROUGH_W + 1)'(1) << rho_q)
                    - ((ROUGH_W + 1)'(1) << hll_rdata);
  assign ev_rough = ROUGH_W'(NUM_REGS) + (ROUGH_W'(1) << rho_q);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR:    if (clr_last) state_d = S_IDLE;
      S_IDLE:     if (accept) state_d = S_HASH;
      S_HASH:     if (step_q == 4'(STEP_LAST) && phase_q) state_d = S_SRCH_RD;
      S_SRCH_RD:  state_d = srch_end ? S_DISPATCH : S_SRCH_CMP;
      S_SRCH_CMP: state_d = key_match ? S_DISPATCH : S_SRCH_RD;
      S_DISPATCH: begin
        if (req_q.op == OP_LOOKUP) state_d = found_q ? S_SEL_RD : S_EMIT;
        else if (found_q) state_d = S_UPD_RD;
        else if (32'(occ_q) < NSLOTS) state_d = S_NEW_WR;
        else state_d = S_WEAK_RD;
      end
      S_UPD_RD:   state_d = S_UPD_CHK;
      S_UPD_CHK:  state_d = (grow && bub_ok) ? S_BUB_RD : S_SEL_RD;
      S_NEW_WR:   state_d = bub_ok ? S_BUB_RD : S_SEL_RD;
      S_BUB_RD:   state_d = S_BUB_CMP;
      S_BUB_CMP:  state_d = bub_swap ? S_BUB_WR : S_SEL_RD;
      S_BUB_WR:   state_d = S_SEL_RD;
      S_WEAK_RD:  state_d = S_WEAK_CHK;
      S_WEAK_CHK: state_d = kick ? S_EV_CLR : S_EMIT;
      S_EV_CLR:   if (ev_last) state_d = S_EV_PRD;
      S_EV_PRD:   state_d = S_EV_PWR;
      S_EV_PWR:   state_d = S_EV_NWR;
      S_EV_NWR:   state_d = S_SEL_RD;
      S_SEL_RD:   state_d = S_EMIT;
      S_EMIT:     state_d = S_IDLE;
      default:    state_d = S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    logic [31:0] t;
    req_d = req_q;  h_d = h_q;  k_d = k_q;  step_d = step_q;  phase_d = phase_q;
    ridx_d = ridx_q;  rho_d = rho_q;  idx_d = idx_q;  found_d = found_q;
    occ_d = occ_q;  ptr_d = ptr_q;  psk_d = psk_q;  thr_d = thr_q;
    margin_d = margin_q;  cur_d = cur_q;  nbr_d = nbr_q;  pos_d = pos_q;
    ks_d = ks_q;  ekey_d = ekey_q;  evicted_d = evicted_q;  hit_d = hit_q;
    cnt_d = cnt_q;  res_d = res_q;  res_valid_d = 1'b0;
    slot_we = 1'b0;  slot_waddr = pos_q;  slot_wdata = cur_q;  slot_raddr = pos_q;
    hll_we = 1'b0;  hll_waddr = cnt_q;  hll_wdata = '0;
    hll_raddr = hll_addr(cur_q.sketch, req_q.reg_select[REG_W-1:0]);
    t = '0;

    // config writes
    if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_WEIGHT_THR: thr_d = cfg_data_i[7:0];
        CFG_PKT_MARGIN: margin_d = cfg_data_i;
        default: ;
      endcase
    end

    unique case (state_q)
      S_CLEAR: begin
        hll_we = 1'b1;
        cnt_d  = cnt_q + 1'b1;
      end
      S_IDLE: begin
        if (accept) begin
          req_d = req_i;  h_d = SEED_IDX;  step_d = '0;  phase_d = 1'b0;
          evicted_d = 1'b0;  ekey_d = '0;
        end
      end
      // hash sequencer, at most one multiply per step
      S_HASH: begin
        step_d = step_q + 4'd1;
        case (step_q)
          4'd0: k_d = req_q.flow_key * MM_C1;
          4'd1, 4'd4: k_d = rotl(k_q, 15) * MM_C2;
          4'd2, 4'd5: h_d = rotl(h_q ^ k_q, 13) * 32'd5 + MM_ADD;
          4'd3: k_d = req_q.element * MM_C1;
          4'd6: begin
            t   = h_q ^ 32'd8;
            t   = t ^ (t >> 16);
            h_d = t * MM_C3;
          end
          4'd7: begin
            t   = h_q ^ (h_q >> 13);
            h_d = t * MM_C4;
          end
          default: begin
            step_d = '0;
            if (!phase_q) begin
              ridx_d  = fin[REG_W-1:0];
              h_d     = SEED_RHO;
              phase_d = 1'b1;
            end else begin
              rho_d   = (lz_p1 < 6'(RHO_MAX)) ? lz_p1[4:0] : RHO_MAX;
              idx_d   = '0;
              found_d = 1'b0;
            end
          end
        endcase
      end
      // linear key search over occupied slots
      S_SRCH_RD: slot_raddr = idx_q[SLOT_W-1:0];
      S_SRCH_CMP: begin
        if (key_match) begin
          found_d = 1'b1;
          cur_d   = slot_rdata;
          pos_d   = idx_q[SLOT_W-1:0];
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      S_DISPATCH: begin
        hit_d = found_q;
        if (req_q.op == OP_INSERT) begin
          if (psk_q != '1) psk_d = psk_q + 32'd1;
          if (!found_q) pos_d = occ_q[SLOT_W-1:0];
        end
      end
      // register update on a tracked flow
      S_UPD_RD: hll_raddr = hll_addr(cur_q.sketch, ridx_q);
      S_UPD_CHK: begin
        if (grow) begin
          hll_we    = 1'b1;
          hll_waddr = hll_addr(cur_q.sketch, ridx_q);
          hll_wdata = rho_q;
          cur_d.rough = upd_sum[ROUGH_W] ? ROUGH_MAX : upd_sum[ROUGH_W-1:0];
          if (hll_rdata == '0 && cur_q.nzm1 != 8'hFF) cur_d.nzm1 = cur_q.nzm1 + 8'd1;
          slot_we    = 1'b1;
          slot_wdata = cur_d;
        end
      end
      // new flow into the next free slot
      S_NEW_WR: begin
        cur_d.key    = req_q.flow_key;
        cur_d.sketch = pos_q;
        cur_d.rough  = ROUGH_W'(1) << rho_q;
        cur_d.nzm1   = '0;
        slot_we      = 1'b1;
        slot_wdata   = cur_d;
        hll_we       = 1'b1;
        hll_waddr    = hll_addr(pos_q, ridx_q);
        hll_wdata    = rho_q;
        occ_d        = occ_q + 1'b1;
        hit_d        = 1'b1;
      end
      // one bubble step toward the head
      S_BUB_RD: slot_raddr = pos_q - 1'b1;
      S_BUB_CMP: begin
        if (bub_swap) begin
          slot_we    = 1'b1;
          slot_waddr = pos_q - 1'b1;
          slot_wdata = cur_q;
          nbr_d      = slot_rdata;
        end
      end
      S_BUB_WR: begin
        slot_we    = 1'b1;
        slot_wdata = nbr_q;
        pos_d      = pos_q - 1'b1;
      end
      // full table: test the weakest top flow
      S_WEAK_RD: slot_raddr = SLOT_W'(TOP_SLOTS - 1);
      S_WEAK_CHK: begin
        if (kick) begin
          ekey_d = slot_rdata.key;
          ks_d   = slot_rdata.sketch;
          cnt_d  = '0;
        end
      end
      S_EV_CLR: begin
        hll_we    = 1'b1;
        hll_waddr = hll_addr(ks_q, cnt_q[REG_W-1:0]);
        cnt_d     = cnt_q + 1'b1;
      end
      S_EV_PRD: slot_raddr = prom;
      S_EV_PWR: begin
        slot_we    = 1'b1;
        slot_waddr = SLOT_W'(TOP_SLOTS - 1);
        slot_wdata = slot_rdata;
      end
      S_EV_NWR: begin
        cur_d.key    = req_q.flow_key;
        cur_d.sketch = ks_q;
        cur_d.rough  = ev_rough;
        cur_d.nzm1   = '0;
        slot_we      = 1'b1;
        slot_waddr   = prom;
        slot_wdata   = cur_d;
        hll_we       = 1'b1;
        hll_waddr    = hll_addr(ks_q, ridx_q);
        hll_wdata    = rho_q;
        pos_d        = prom;
        ptr_d        = (32'(prom) + 1 >= NSLOTS) ? SLOT_W'(TOP_SLOTS) : prom + 1'b1;
        psk_d        = '0;
        evicted_d    = 1'b1;
        hit_d        = 1'b1;
      end
      S_SEL_RD: ;
      S_EMIT: begin
        res_valid_d = 1'b1;
        res_d       = '0;
        if (hit_q) begin
          res_d.tracked      = 1'b1;
          res_d.slot         = 10'(pos_q);
          res_d.evicted      = evicted_q;
          res_d.evicted_key  = ekey_q;
          res_d.rough_sum    = cur_q.rough;
          res_d.nonzero_regs = {1'b0, cur_q.nzm1} + 9'd1;
          res_d.reg_value    = (32'(req_q.reg_select) < NUM_REGS) ? hll_rdata : 5'd0;
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      cnt_q       <= '0;
      occ_q       <= '0;
      ptr_q       <= SLOT_W'(TOP_SLOTS);
      psk_q       <= '0;
      thr_q       <= 8'd64;
      margin_q    <= 32'd6400;
      res_valid_q <= 1'b0;
      step_q      <= '0;
      phase_q     <= 1'b0;
      idx_q       <= '0;
      found_q     <= 1'b0;
      hit_q       <= 1'b0;
      evicted_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      occ_q       <= occ_d;
      ptr_q       <= ptr_d;
      psk_q       <= psk_d;
      thr_q       <= thr_d;
      margin_q    <= margin_d;
      res_valid_q <= res_valid_d;
      step_q      <= step_d;
      phase_q     <= phase_d;
      idx_q       <= idx_d;
      found_q     <= found_d;
      hit_q       <= hit_d;
      evicted_q   <= evicted_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    req_q  <= req_d;
    h_q    <= h_d;
    k_q    <= k_d;
    ridx_q <= ridx_d;
    rho_q  <= rho_d;
    cur_q  <= cur_d;
    nbr_q  <= nbr_d;
    pos_q  <= pos_d;
    ks_q   <= ks_d;
    ekey_q <= ekey_d;
    res_q  <= res_d;
  end

  assign busy        = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule
